FILE: hdl/cms_pkg.sv
// ----------------------------------------------------------------------------
// Cube-map sampler package
// Shared widths, codes, item types and warp coefficients.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cms_pkg;

  localparam int MAX_RES    = 256;
  localparam int FACES      = 6;
  localparam int DIR_BITS   = 24;
  localparam int COORD_W    = $clog2(MAX_RES);
  localparam int RES_W      = 9;
  localparam int FACE_W     = 3;
  localparam int CH_W       = 16;
  localparam int CHANNELS   = 3;
  localparam int UV_W       = 17;
  localparam int NUM_W      = DIR_BITS + UV_W;
  localparam int DIV_LAT    = UV_W + 1;
  localparam int WARP_LAT   = 12;
  localparam int LINE_LEN   = DIV_LAT + WARP_LAT;
  localparam int BANK_DEPTH = FACES * (MAX_RES / 2) * (MAX_RES / 2);
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  // warp polynomial, Q.24
  localparam int P_W      = 27;
  localparam int PROD_W   = P_W + UV_W + 1;
  localparam int HORNER_N = 4;
  localparam logic signed [P_W-1:0] WARP_C9 = 27'sd445067;
  localparam logic signed [P_W-1:0] HORNER_ADD [HORNER_N] = '{
    -27'sd1818561, 27'sd3848067, -27'sd7055665, 27'sd21358552
  };

  localparam logic [UV_W-1:0] UV_HALF = 17'h08000;
  localparam logic [UV_W-1:0] WGT_ONE = 17'h10000;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic REG_GRID_RES = 1'b0;

  localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
  localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
  localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

  typedef logic [CHANNELS-1:0][CH_W-1:0] texel_t;

  typedef struct packed {
    logic                       command;
    logic [FACE_W-1:0]          face_select;
    logic [COORD_W-1:0]         texel_x;
    logic [COORD_W-1:0]         texel_y;
    logic [CH_W-1:0]            elevation_in;
    logic [CH_W-1:0]            land_in;
    logic [CH_W-1:0]            biome_in;
    logic signed [DIR_BITS-1:0] dir_x;
    logic signed [DIR_BITS-1:0] dir_y;
    logic signed [DIR_BITS-1:0] dir_z;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic [FACE_W-1:0] face_out;
    logic [UV_W-1:0]   u_out;
    logic [UV_W-1:0]   v_out;
    logic [CH_W-1:0]   elevation_out;
    logic [CH_W-1:0]   land_out;
    logic [CH_W-1:0]   biome_out;
  } out_item_t;

  // per-item control carried alongside the coordinate pipeline
  typedef struct packed {
    logic               command;
    logic               wr_ok;
    logic               smp_ok;
    logic [FACE_W-1:0]  face;
    logic [COORD_W-1:0] wx;
    logic [COORD_W-1:0] wy;
    texel_t             wdata;
    logic               nu;
    logic               nv;
  } side_t;

endpackage

`default_nettype wire

FILE: hdl/cms_div.sv
// ----------------------------------------------------------------------------
// Ratio divider
// Rounded minor/major ratio in Q1.16, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cms_div (
  input  logic                         clk,
  input  logic [cms_pkg::DIR_BITS-1:0] num,
  input  logic [cms_pkg::DIR_BITS-1:0] den,
  output logic [cms_pkg::UV_W-1:0]     quo
);
  import cms_pkg::*;

  logic [NUM_W-1:0]    dividend;
  logic [DIR_BITS-1:0] rem_r [0:DIV_LAT-2];
  logic [DIR_BITS-1:0] den_r [0:DIV_LAT-2];
  logic [UV_W-1:0]     low_r [0:DIV_LAT-2];
  logic [UV_W-1:0]     quo_r [0:DIV_LAT-1];
  logic [DIR_BITS:0]   trial [1:DIV_LAT-1];
  logic [DIR_BITS:0]   diff  [1:DIV_LAT-1];

  // add half the divisor up front so truncation rounds to nearest
  assign dividend = NUM_W'({num, {(UV_W-1){1'b0}}}) + NUM_W'(den >> 1);

  always_comb begin
    for (int k = 1; k < DIV_LAT; k++) begin
      trial[k] = {rem_r[k-1], low_r[k-1][UV_W-k]};
      diff[k]  = trial[k] - {1'b0, den_r[k-1]};
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= dividend[NUM_W-1:UV_W];
    low_r[0] <= dividend[UV_W-1:0];
    den_r[0] <= den;
    quo_r[0] <= '0;
    for (int k = 1; k < DIV_LAT; k++) begin
      quo_r[k] <= {quo_r[k-1][UV_W-2:0], ~diff[k][DIR_BITS]};
    end
    for (int k = 1; k < DIV_LAT - 1; k++) begin
      den_r[k] <= den_r[k-1];
      low_r[k] <= low_r[k-1];
      rem_r[k] <= diff[k][DIR_BITS] ? trial[k][DIR_BITS-1:0] : diff[k][DIR_BITS-1:0];
    end
  end

  assign quo = quo_r[DIV_LAT-1];

endmodule

`default_nettype wire

FILE: hdl/cms_warp.sv
// ----------------------------------------------------------------------------
// Equiangular warp
// Odd polynomial approximation of (4/pi) atan(r), pipelined by Horner step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cms_warp (
  input  logic                     clk,
  input  logic [cms_pkg::UV_W-1:0] ratio,
  input  logic                     neg,
  output logic [cms_pkg::UV_W-1:0] coord
);
  import cms_pkg::*;

  localparam int SQ_W = 2 * UV_W;
  localparam int HP_W = P_W - 1 + UV_W;

  logic [SQ_W-1:0]          sq_r;
  logic [SQ_W:0]            sq_rnd;
  logic [UV_W-1:0]          r_r [0:9];
  logic                     n_r [0:10];
  logic [UV_W-1:0]          s_r [1:7];
  logic signed [P_W-1:0]    p_op [HORNER_N];
  logic signed [PROD_W-1:0] prod_r [HORNER_N];
  logic signed [P_W-1:0]    p_r [HORNER_N];
  logic [P_W-2:0]           p_pos;
  logic [HP_W-1:0]          hp_r;
  logic [HP_W:0]            hp_rnd;
  logic [UV_W-1:0]          h;
  logic [UV_W-1:0]          coord_r;

  // product >> 16, rounded half away from zero
  function automatic logic signed [P_W-1:0] round16(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-1:0]     mag;
    logic [PROD_W-1:0]     rnd;
    logic signed [P_W-1:0] q;
    mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    rnd = (mag + PROD_W'(32768)) >> 16;
    q   = signed'(rnd[P_W-1:0]);
    return v[PROD_W-1] ? -q : q;
  endfunction

  assign sq_rnd = {1'b0, sq_r} + (SQ_W+1)'(32768);

  always_comb begin
    p_op[0] = WARP_C9;
    for (int k = 1; k < HORNER_N; k++) begin
      p_op[k] = p_r[k-1];
    end
  end

  assign p_pos  = p_r[HORNER_N-1][P_W-1] ? '0 : p_r[HORNER_N-1][P_W-2:0];
  assign hp_rnd = {1'b0, hp_r} + (HP_W+1)'(1 << 24);
  assign h      = (hp_rnd[HP_W:25] > (HP_W-24)'(UV_HALF)) ? UV_HALF
                                                         : UV_W'(hp_rnd[HP_W:25]);

  always_ff @(posedge clk) begin
    sq_r   <= ratio * ratio;
    r_r[0] <= ratio;
    n_r[0] <= neg;
    for (int i = 1; i < 10; i++) begin
      r_r[i] <= r_r[i-1];
    end
    for (int i = 1; i < 11; i++) begin
      n_r[i] <= n_r[i-1];
    end
    s_r[1] <= sq_rnd[UV_W+15:16];
    for (int i = 2; i < 8; i++) begin
      s_r[i] <= s_r[i-1];
    end
    for (int k = 0; k < HORNER_N; k++) begin
      prod_r[k] <= p_op[k] * $signed({1'b0, s_r[1+2*k]});
      p_r[k]    <= round16(prod_r[k]) + HORNER_ADD[k];
    end
    hp_r    <= p_pos * r_r[9];
    coord_r <= n_r[10] ? (UV_HALF - h) : (UV_HALF + h);
  end

  assign coord = coord_r;

endmodule

`default_nettype wire

FILE: hdl/cms_bank.sv
// ----------------------------------------------------------------------------
// Texel bank
// One parity bank of the texel store: one write and one registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cms_bank (
  input  logic                        clk,
  input  logic                        we,
  input  logic [cms_pkg::BANK_AW-1:0] waddr,
  input  cms_pkg::texel_t             wdata,
  input  logic [cms_pkg::BANK_AW-1:0] raddr,
  output cms_pkg::texel_t             rdata
);
  import cms_pkg::*;

  texel_t mem [0:BANK_DEPTH-1];
  texel_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hdl/cms_blend.sv
// ----------------------------------------------------------------------------
// Bilinear blend
// Grid position, banked texel fetch and write, two-pass blend and rounding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cms_blend (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  cms_pkg::side_t            in_side,
  input  logic [cms_pkg::UV_W-1:0]  in_u,
  input  logic [cms_pkg::UV_W-1:0]  in_v,
  input  logic [cms_pkg::RES_W-1:0] res,
  output logic                      out_valid,
  output cms_pkg::out_item_t        out_result
);
  import cms_pkg::*;

  localparam int GX_W  = UV_W + COORD_W;
  localparam int ROW_W = CH_W + UV_W;
  localparam int TOT_W = ROW_W + UV_W;
  localparam int HW    = COORD_W - 1;

  logic                vld1_r, vld2_r, vld3_r, vld4_r, vld5_r;
  side_t               side1_r, side2_r;
  logic [UV_W-1:0]     cu1_r, cv1_r, cu2_r, cv2_r;
  logic [GX_W-1:0]     gx1_r, gy1_r;
  logic [COORD_W-1:0]  rm1;
  logic [COORD_W:0]    x0w, y0w;
  logic [COORD_W-1:0]  x0, x1, y0, y1;
  logic [CH_W-1:0]     fx2_r, fy2_r, fy3_r;
  logic                px0_r, px1_r, py0_r, py1_r;
  logic [BANK_AW-1:0]  raddr [4];
  logic [BANK_AW-1:0]  waddr;
  logic                we [4];
  texel_t              rd [4];
  texel_t              t00, t10, t01, t11;
  logic [UV_W-1:0]     wfx, wfy;
  logic [ROW_W-1:0]    row0_r [CHANNELS];
  logic [ROW_W-1:0]    row1_r [CHANNELS];
  logic [TOT_W-1:0]    tot_r  [CHANNELS];
  logic [TOT_W-1:0]    tot_sum [CHANNELS];
  out_item_t           hdr3_nxt, hdr3_r, hdr4_r, out_nxt, out_r;
  logic                fill3_nxt, fill3_r, fill4_r;

  assign rm1 = res[COORD_W-1:0] - COORD_W'(1);

  // grid cell and neighbor, clamped at the far edge
  assign x0w = gx1_r[GX_W-1:16];
  assign y0w = gy1_r[GX_W-1:16];
  assign x0  = (x0w > {1'b0, rm1}) ? rm1 : x0w[COORD_W-1:0];
  assign y0  = (y0w > {1'b0, rm1}) ? rm1 : y0w[COORD_W-1:0];
  assign x1  = (x0 < rm1) ? x0 + COORD_W'(1) : rm1;
  assign y1  = (y0 < rm1) ? y0 + COORD_W'(1) : rm1;

  assign waddr = {side1_r.face, side1_r.wy[COORD_W-1:1], side1_r.wx[COORD_W-1:1]};

  always_comb begin
    logic [1:0] bsel;
    logic [HW-1:0] xh, yh;
    for (int b = 0; b < 4; b++) begin
      bsel     = 2'(b);
      xh       = (x0[0] == bsel[0]) ? x0[COORD_W-1:1] : x1[COORD_W-1:1];
      yh       = (y0[0] == bsel[1]) ? y0[COORD_W-1:1] : y1[COORD_W-1:1];
      raddr[b] = {side1_r.face, yh, xh};
      we[b]    = vld1_r && (side1_r.command == CMD_WRITE) && side1_r.wr_ok &&
                 ({side1_r.wy[0], side1_r.wx[0]} == bsel);
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    cms_bank u_bank (
      .clk   (clk),
      .we    (we[b]),
      .waddr (waddr),
      .wdata (side1_r.wdata),
      .raddr (raddr[b]),
      .rdata (rd[b])
    );
  end

  assign t00 = rd[{py0_r, px0_r}];
  assign t10 = rd[{py0_r, px1_r}];
  assign t01 = rd[{py1_r, px0_r}];
  assign t11 = rd[{py1_r, px1_r}];
  assign wfx = WGT_ONE - {1'b0, fx2_r};
  assign wfy = WGT_ONE - {1'b0, fy3_r};

  always_comb begin
    hdr3_nxt  = '0;
    fill3_nxt = 1'b0;
    if (side2_r.command == CMD_SAMPLE) begin
      if (side2_r.smp_ok) begin
        hdr3_nxt.ok       = 1'b1;
        hdr3_nxt.face_out = side2_r.face;
        hdr3_nxt.u_out    = cu2_r;
        hdr3_nxt.v_out    = cv2_r;
        fill3_nxt         = 1'b1;
      end
    end else begin
      hdr3_nxt.ok = side2_r.wr_ok;
    end
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      tot_sum[c] = tot_r[c] + TOT_W'(64'd1 << 31);
    end
    out_nxt = hdr4_r;
    if (fill4_r) begin
      out_nxt.elevation_out = tot_sum[0][CH_W+31:32];
      out_nxt.land_out      = tot_sum[1][CH_W+31:32];
      out_nxt.biome_out     = tot_sum[2][CH_W+31:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
    end else begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
    end
  end

  always_ff @(posedge clk) begin
    side1_r <= in_side;
    cu1_r   <= in_u;
    cv1_r   <= in_v;
    gx1_r   <= in_u * rm1;
    gy1_r   <= in_v * rm1;

    side2_r <= side1_r;
    cu2_r   <= cu1_r;
    cv2_r   <= cv1_r;
    fx2_r   <= gx1_r[CH_W-1:0];
    fy2_r   <= gy1_r[CH_W-1:0];
    px0_r   <= x0[0];
    px1_r   <= x1[0];
    py0_r   <= y0[0];
    py1_r   <= y1[0];

    hdr3_r  <= hdr3_nxt;
    fill3_r <= fill3_nxt;
    fy3_r   <= fy2_r;
    for (int c = 0; c < CHANNELS; c++) begin
      row0_r[c] <= t00[c] * wfx + t10[c] * fx2_r;
      row1_r[c] <= t01[c] * wfx + t11[c] * fx2_r;
      tot_r[c]  <= row0_r[c] * wfy + row1_r[c] * fy3_r;
    end

    hdr4_r  <= hdr3_r;
    fill4_r <= fill3_r;
    out_r   <= out_nxt;
  end

  assign out_valid  = vld5_r;
  assign out_result = out_r;

endmodule

`default_nettype wire

FILE: hdl/cube_map_heightmap_sampler_core.sv
// ----------------------------------------------------------------------------
// Cube-map heightmap sampler, top level
// One item per cycle, busy never rises; out_valid strobes once for each accepted item.
// The path runs through the 18-stage ratio divider, 12-stage warp and banked blend.
// Reset clears grid_resolution and valid bits; the texel store is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cube_map_heightmap_sampler_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cms_pkg::in_item_t in_item,
  output logic              out_valid,
  output cms_pkg::out_item_t out_result,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import cms_pkg::*;

  logic [RES_W-1:0]    grid_res_r;
  logic                usable;
  logic                vld_s0_r, vld_s1_r, vld_s2_r;
  in_item_t            in_r;
  logic [DIR_BITS-1:0] ax_r, ay_r, az_r;
  logic                nx_r, ny_r, nz_r, usable_s1_r;
  side_t               side_s1_nxt, side_s1_r, side_s2_nxt, side_s2_r;
  logic [DIR_BITS-1:0] major_nxt, mu_nxt, mv_nxt, major_r, mu_r, mv_r;
  side_t               side_line_r [0:LINE_LEN-1];
  logic                vld_line_r  [0:LINE_LEN-1];
  logic [UV_W-1:0]     quo_u, quo_v, coord_u, coord_v;

  function automatic logic [DIR_BITS-1:0] dir_mag(input logic signed [DIR_BITS-1:0] d);
    return d[DIR_BITS-1] ? DIR_BITS'(-d) : DIR_BITS'(d);
  endfunction

  // configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_res_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_GRID_RES)) begin
      grid_res_r <= cfg_pwdata[RES_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_GRID_RES) ? 32'(grid_res_r) : '0;
  assign busy       = 1'b0;

  assign usable = (grid_res_r >= RES_W'(2)) && (grid_res_r <= RES_W'(MAX_RES));

  always_comb begin
    side_s1_nxt         = '0;
    side_s1_nxt.command = in_r.command;
    side_s1_nxt.face    = in_r.face_select;
    side_s1_nxt.wx      = in_r.texel_x;
    side_s1_nxt.wy      = in_r.texel_y;
    side_s1_nxt.wdata   = {in_r.biome_in, in_r.land_in, in_r.elevation_in};
    side_s1_nxt.wr_ok   = usable && (in_r.face_select < FACE_W'(FACES)) &&
                          ({1'b0, in_r.texel_x} < grid_res_r) &&
                          ({1'b0, in_r.texel_y} < grid_res_r);
  end

  // pick the major axis, ties go to X then Y
  always_comb begin
    side_s2_nxt        = side_s1_r;
    side_s2_nxt.smp_ok = usable_s1_r && ((ax_r | ay_r | az_r) != '0);
    major_nxt          = ax_r;
    mu_nxt             = ay_r;
    mv_nxt             = az_r;
    if (side_s1_r.command == CMD_SAMPLE) begin
      priority if (ax_r >= ay_r && ax_r >= az_r) begin
        major_nxt        = ax_r;
        side_s2_nxt.face = nx_r ? FACE_NX : FACE_PX;
        mu_nxt           = ay_r;
        side_s2_nxt.nu   = nx_r ? !ny_r : ny_r;
        mv_nxt           = az_r;
        side_s2_nxt.nv   = nz_r;
      end else if (ay_r >= az_r) begin
        major_nxt        = ay_r;
        side_s2_nxt.face = ny_r ? FACE_NY : FACE_PY;
        mu_nxt           = ax_r;
        side_s2_nxt.nu   = ny_r ? nx_r : !nx_r;
        mv_nxt           = az_r;
        side_s2_nxt.nv   = nz_r;
      end else begin
        major_nxt        = az_r;
        side_s2_nxt.face = nz_r ? FACE_NZ : FACE_PZ;
        mu_nxt           = ax_r;
        side_s2_nxt.nu   = nx_r;
        mv_nxt           = ay_r;
        side_s2_nxt.nv   = nz_r ? !ny_r : ny_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_s0_r <= 1'b0;
      vld_s1_r <= 1'b0;
      vld_s2_r <= 1'b0;
      for (int i = 0; i < LINE_LEN; i++) begin
        vld_line_r[i] <= 1'b0;
      end
    end else begin
      vld_s0_r      <= start && !busy;
      vld_s1_r      <= vld_s0_r;
      vld_s2_r      <= vld_s1_r;
      vld_line_r[0] <= vld_s2_r;
      for (int i = 1; i < LINE_LEN; i++) begin
        vld_line_r[i] <= vld_line_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_item;
    end
    ax_r        <= dir_mag(in_r.dir_x);
    ay_r        <= dir_mag(in_r.dir_y);
    az_r        <= dir_mag(in_r.dir_z);
    nx_r        <= in_r.dir_x[DIR_BITS-1];
    ny_r        <= in_r.dir_y[DIR_BITS-1];
    nz_r        <= in_r.dir_z[DIR_BITS-1];
    usable_s1_r <= usable;
    side_s1_r   <= side_s1_nxt;

    side_s2_r <= side_s2_nxt;
    major_r   <= major_nxt;
    mu_r      <= mu_nxt;
    mv_r      <= mv_nxt;

    side_line_r[0] <= side_s2_r;
    for (int i = 1; i < LINE_LEN; i++) begin
      side_line_r[i] <= side_line_r[i-1];
    end
  end

  cms_div u_div_u (
    .clk (clk),
    .num (mu_r),
    .den (major_r),
    .quo (quo_u)
  );

  cms_div u_div_v (
    .clk (clk),
    .num (mv_r),
    .den (major_r),
    .quo (quo_v)
  );

  cms_warp u_warp_u (
    .clk   (clk),
    .ratio (quo_u),
    .neg   (side_line_r[DIV_LAT-1].nu),
    .coord (coord_u)
  );

  cms_warp u_warp_v (
    .clk   (clk),
    .ratio (quo_v),
    .neg   (side_line_r[DIV_LAT-1].nv),
    .coord (coord_v)
  );

  cms_blend u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (vld_line_r[LINE_LEN-1]),
    .in_side    (side_line_r[LINE_LEN-1]),
    .in_u       (coord_u),
    .in_v       (coord_v),
    .res        (grid_res_r),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule

`default_nettype wire

FILE: bench/cube_map_sampler_checker.sv
// ----------------------------------------------------------------------------
// Cube-map sampler checker
// Tracks the grid resolution register and the texel store, predicts the result
// of every accepted item and compares it field by field with the block output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cube_map_sampler_checker
  import cms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  out_item_t   out_result,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          errors,
  output int          pending
);

  logic [RES_W-1:0] grid_res;
  texel_t           texels [int];
  out_item_t        expected_q [$];

  function automatic longint round_sh16(longint v);
    if (v >= 0) return (v + 32768) >>> 16;
    return -((-v + 32768) >>> 16);
  endfunction

  // equiangular warp of one minor component, Q1.16
  function automatic logic [UV_W-1:0] warp_coord(longint num, logic neg, longint den);
    longint r, s, p, h;
    r = (num * 65536 + den / 2) / den;
    if (r > 65536) r = 65536;
    s = (r * r + 32768) >>> 16;
    p = 445067;
    p = round_sh16(p * s) - 1818561;
    p = round_sh16(p * s) + 3848067;
    p = round_sh16(p * s) - 7055665;
    p = round_sh16(p * s) + 21358552;
    if (p < 0) p = 0;
    h = (p * r + (64'd1 << 24)) >>> 25;
    if (h > 32768) h = 32768;
    return neg ? UV_W'(32768 - h) : UV_W'(32768 + h);
  endfunction

  function automatic int texel_addr(int face, int y, int x);
    return (face * MAX_RES + y) * MAX_RES + x;
  endfunction

  function automatic out_item_t predict_item(in_item_t it);
    out_item_t o;
    int        res, face, x0, x1, y0, y1, ch;
    longint    ax, ay, az, major, mu, mv, gx, gy, fx, fy, row0, row1, total;
    logic      nx, ny, nz, nu, nv;
    longint unsigned c00, c10, c01, c11;
    o = '0;
    res = grid_res;
    if (res < 2 || res > MAX_RES) return o;
    if (it.command == CMD_WRITE) begin
      if (it.face_select < FACES && it.texel_x < res && it.texel_y < res) begin
        texels[texel_addr(it.face_select, it.texel_y, it.texel_x)] =
          {it.biome_in, it.land_in, it.elevation_in};
        o.ok = 1'b1;
      end
      return o;
    end
    ax = it.dir_x; ay = it.dir_y; az = it.dir_z;
    nx = ax < 0; ny = ay < 0; nz = az < 0;
    if (nx) ax = -ax;
    if (ny) ay = -ay;
    if (nz) az = -az;
    if (ax == 0 && ay == 0 && az == 0) return o;
    if (ax >= ay && ax >= az) begin
      major = ax; face = nx ? FACE_NX : FACE_PX;
      mu = ay; nu = nx ? !ny : ny; mv = az; nv = nz;
    end else if (ay >= az) begin
      major = ay; face = ny ? FACE_NY : FACE_PY;
      mu = ax; nu = ny ? nx : !nx; mv = az; nv = nz;
    end else begin
      major = az; face = nz ? FACE_NZ : FACE_PZ;
      mu = ax; nu = nx; mv = ay; nv = nz ? !ny : ny;
    end
    o.ok = 1'b1;
    o.face_out = FACE_W'(face);
    o.u_out = warp_coord(mu, nu, major);
    o.v_out = warp_coord(mv, nv, major);
    gx = longint'(o.u_out) * (res - 1);
    gy = longint'(o.v_out) * (res - 1);
    x0 = int'(gx >>> 16); y0 = int'(gy >>> 16);
    if (x0 > res - 1) x0 = res - 1;
    if (y0 > res - 1) y0 = res - 1;
    x1 = (x0 + 1 < res) ? x0 + 1 : res - 1;
    y1 = (y0 + 1 < res) ? y0 + 1 : res - 1;
    fx = gx & 16'hFFFF; fy = gy & 16'hFFFF;
    for (ch = 0; ch < CHANNELS; ch++) begin
      c00 = texels[texel_addr(face, y0, x0)][ch];
      c10 = texels[texel_addr(face, y0, x1)][ch];
      c01 = texels[texel_addr(face, y1, x0)][ch];
      c11 = texels[texel_addr(face, y1, x1)][ch];
      row0 = c00 * (65536 - fx) + c10 * fx;
      row1 = c01 * (65536 - fx) + c11 * fx;
      total = (row0 * (65536 - fy) + row1 * fy + (64'd1 << 31)) >>> 32;
      if (ch == 0) o.elevation_out = CH_W'(total);
      else if (ch == 1) o.land_out = CH_W'(total);
      else o.biome_out = CH_W'(total);
    end
    return o;
  endfunction

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      grid_res = '0;
      expected_q.delete();
      errors = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == {REG_GRID_RES, 2'b00})
        grid_res = cfg_pwdata[RES_W-1:0];
      if (start && !busy)
        expected_q.push_back(predict_item(in_item));
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $error("result with no item outstanding: %p", out_result);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_result.ok !== e.ok) begin
            $error("ok: expected %0d actual %0d", e.ok, out_result.ok); errors++;
          end
          if (out_result.face_out !== e.face_out) begin
            $error("face_out: expected %0d actual %0d", e.face_out, out_result.face_out);
            errors++;
          end
          if (out_result.u_out !== e.u_out) begin
            $error("u_out: expected %0d actual %0d", e.u_out, out_result.u_out); errors++;
          end
          if (out_result.v_out !== e.v_out) begin
            $error("v_out: expected %0d actual %0d", e.v_out, out_result.v_out); errors++;
          end
          if (out_result.elevation_out !== e.elevation_out) begin
            $error("elevation_out: expected %0d actual %0d", e.elevation_out,
                   out_result.elevation_out);
            errors++;
          end
          if (out_result.land_out !== e.land_out) begin
            $error("land_out: expected %0d actual %0d", e.land_out, out_result.land_out);
            errors++;
          end
          if (out_result.biome_out !== e.biome_out) begin
            $error("biome_out: expected %0d actual %0d", e.biome_out, out_result.biome_out);
            errors++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

`default_nettype wire

FILE: bench/cube_map_heightmap_sampler_core_tb.sv
// ----------------------------------------------------------------------------
// Cube-map heightmap sampler testbench
// Fills faces at several grid resolutions, then samples directed and random
// directions; invalid resolutions and out-of-range writes are mixed in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cube_map_heightmap_sampler_core_tb;
  import cms_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_result;
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  int          errors, pending;
  int          n_writes, n_samples;
  logic        no_idle;

  cube_map_heightmap_sampler_core u_dut (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_result,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  cube_map_sampler_checker u_chk (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_result,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("cube_map_heightmap_sampler_core_tb NOT OK");
    $finish;
  end

  task automatic send(in_item_t it);
    int gap;
    in_item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (it.command == CMD_WRITE) n_writes++; else n_samples++;
    if (!no_idle && $urandom_range(99) < 9) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the sender until every item has returned
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_grid_res(int res);
    drain();
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {REG_GRID_RES, 2'b00};
    cfg_pwdata <= {$urandom_range(0, 1) ? 23'($urandom) : 23'd0, RES_W'(res)};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CH_W-1:0] rnd_chan();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return CH_W'($urandom);
    endcase
  endfunction

  function automatic in_item_t write_item(int face, int x, int y);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.command = CMD_WRITE;
    it.face_select = FACE_W'(face);
    it.texel_x = COORD_W'(x);
    it.texel_y = COORD_W'(y);
    it.elevation_in = rnd_chan();
    it.land_in = rnd_chan();
    it.biome_in = rnd_chan();
    return it;
  endfunction

  function automatic in_item_t sample_item(int x, int y, int z);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.command = CMD_SAMPLE;
    it.dir_x = DIR_BITS'(x);
    it.dir_y = DIR_BITS'(y);
    it.dir_z = DIR_BITS'(z);
    return it;
  endfunction

  function automatic int rnd_comp();
    case ($urandom_range(4))
      0: return $urandom_range(0, 8) - 4;
      1: return $urandom_range(0, 1) ? 8388607 : -8388608;
      default: return int'(signed'(DIR_BITS'($urandom)));
    endcase
  endfunction

  task automatic fill_faces(int res);
    for (int f = 0; f < FACES; f++)
      for (int y = 0; y < res; y++)
        for (int x = 0; x < res; x++)
          send(write_item(f, x, y));
  endtask

  task automatic random_samples(int count);
    int x, y, z;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) begin
        // noise: write at random face and coordinates, often out of range
        send(write_item($urandom_range(0, 7), $urandom_range(0, 255),
                        $urandom_range(0, 255)));
      end else begin
        x = rnd_comp(); y = rnd_comp(); z = rnd_comp();
        case ($urandom_range(5))
          0: y = $urandom_range(0, 1) ? x : -x;
          1: z = $urandom_range(0, 1) ? y : -y;
          2: begin y = x; z = -x; end
          default: ;
        endcase
        if (x == -8388608 && y == 8388607) y = -8388608;
        send(sample_item(x, y, z));
      end
    end
  endtask

  // at full size only the center, corner and edge-center texels of the two
  // X faces are written, and every sample lands on an X face
  task automatic sparse_full_size(int count);
    int pts [8] = '{0, 1, 126, 127, 128, 129, 254, 255};
    int v [3];
    int major;
    for (int f = FACE_PX; f <= FACE_NX; f++)
      foreach (pts[j])
        foreach (pts[k])
          send(write_item(f, pts[k], pts[j]));
    send(sample_item(-8388608, -8388608, -8388608));
    send(sample_item(8388607, 8388607, 8388607));
    for (int i = 0; i < count; i++) begin
      major = $urandom_range(1 << 20, 8388607);
      v[0] = $urandom_range(0, 1) ? major : -major;
      for (int c = 1; c < 3; c++) begin
        if ($urandom_range(0, 2) == 0)
          v[c] = $urandom_range(0, 1) ? major : -major;
        else
          v[c] = $urandom_range(0, major / 256) * ($urandom_range(0, 1) ? 1 : -1);
      end
      send(sample_item(v[0], v[1], v[2]));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    no_idle = 1'b0;
    n_writes = 0; n_samples = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // grid unset after reset: everything is rejected
    send(write_item(FACE_PX, 0, 0));
    send(sample_item(5, 1, 1));
    random_samples(16);

    set_grid_res(2);
    fill_faces(2);
    send(write_item(6, 0, 0));
    send(write_item(7, 1, 1));
    send(write_item(FACE_PX, 2, 0));
    send(write_item(FACE_NZ, 0, 255));
    send(sample_item(0, 0, 0));
    send(sample_item(100, 0, 0));
    send(sample_item(-100, 0, 0));
    send(sample_item(0, 100, 0));
    send(sample_item(0, -100, 0));
    send(sample_item(0, 0, 100));
    send(sample_item(0, 0, -100));
    send(sample_item(7, 7, 7));
    send(sample_item(-7, -7, -7));
    send(sample_item(9, -9, 3));
    send(sample_item(2, 9, -9));
    send(sample_item(-8388608, 8388607, -8388608));
    send(sample_item(8388607, -8388608, 1));
    send(sample_item(1, 0, -1));
    random_samples(40);

    set_grid_res(3);
    fill_faces(3);
    random_samples(40);

    no_idle = 1'b1;
    set_grid_res(4);
    fill_faces(4);
    random_samples(60);
    no_idle = 1'b0;

    set_grid_res(MAX_RES);
    sparse_full_size(60);

    set_grid_res(300);
    random_samples(10);
    set_grid_res(1);
    random_samples(10);
    set_grid_res(511);
    random_samples(5);

    drain();
    $display("Ran %0d texel writes and %0d direction samples at resolutions", n_writes,
             n_samples);
    $display("0, 1, 2, 3, 4, 256, 300 and 511, with ties and extreme directions.");
    if (errors == 0)
      $display("cube_map_heightmap_sampler_core_tb OK");
    else
      $display("cube_map_heightmap_sampler_core_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
